/* design/ffua_pkg.sv */
// Package for the first-fit unit allocator: field widths, codes, FSM state
// type and the command/status structs shared by controller and datapath.
// No dependencies.
package ffua_pkg;

    localparam int MAX_UNITS_DEF = 1024;
    localparam int ID_BITS_DEF   = 10;

    localparam int REQ_W   = 11;
    localparam int OID_W   = 10;
    localparam int START_W = 10;
    localparam int FREED_W = 11;
    localparam int SIZE_W  = 11;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = 11'd1024;
    localparam logic [FREED_W-1:0] FREED_MAX  = '1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STS_OK      = 1'b0;
    localparam logic STS_NOSPACE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ALLOC,
        ST_FILL,
        ST_FREE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_en;
        logic alloc_en;
        logic fill_en;
        logic free_en;
        logic set_fail;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic func_free;
        logic alloc_ok;
        logic id_ok;
        logic found;
        logic scan_end;
        logic free_end;
        logic fill_last;
        logic clr_last;
    } sts_t;

endpackage

/* design/first_fit_unit_allocator_core.sv */
// Top level of the first-fit unit allocator: stream ports, size register
// port, controller and datapath. Depends on ffua_pkg, ffua_ctrl, ffua_dpath.
//
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_data: memory_units
//  s       | in        | s_tvalid/tready    | tuser: func; tdata: request_units, owner_id
//  m       | out       | m_tvalid/tready    | tuser: status; tdata: start_index, freed_units
//
// Allocate: units are scanned up to the end of the first fitting run, then each
// unit of the run is marked with the owner id; a scan that finds no run reads every
// unit below the smaller of the size and MAX_UNITS, and a request refused on its
// length or id is not scanned. Free: the whole table is scanned through the
// one-unit-a-cycle table read port, but not for id 0. After reset the owner table is cleared before any item.
// A result waiting at m holds the next item's result back, not its acceptance.
module first_fit_unit_allocator_core
#(
    parameter int MAX_UNITS = ffua_pkg::MAX_UNITS_DEF,
    parameter int ID_BITS   = ffua_pkg::ID_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data,   // memory_units
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // request_units[10:0], owner_id[20:11], zero pad
    input  logic [0:0]  s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // start_index[9:0], freed_units[20:10], zero pad
    output logic [0:0]  m_tuser     // status
);
    import ffua_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic               out_status;
    logic [START_W-1:0] out_start;
    logic [FREED_W-1:0] out_freed;

    assign cfg_ready = 1'b1;

    ffua_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffua_dpath #(
        .MAX_UNITS (MAX_UNITS),
        .ID_BITS   (ID_BITS)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_size   (cfg_data),
        .in_func    (s_tuser[0]),
        .in_req     (s_tdata[10:0]),
        .in_id      (s_tdata[20:11]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (out_status),
        .out_start  (out_start),
        .out_freed  (out_freed)
    );

    assign m_tdata = {3'b000, out_freed, out_start};
    assign m_tuser = out_status;

endmodule

/* design/ffua_ctrl.sv */
// Controller FSM of the first-fit unit allocator: sequences clearing,
// scanning, filling and result hand-off. Depends on ffua_pkg.
module ffua_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  ffua_pkg::sts_t sts,
    output ffua_pkg::cmd_t cmd
);
    import ffua_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.func_free)
                    state_next = sts.id_ok ? ST_FREE : ST_DONE;
                else if (sts.alloc_ok)
                    state_next = ST_ALLOC;
                else
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc_en = 1'b1;
                if (sts.found)
                    state_next = ST_FILL;
                else if (sts.scan_end)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cmd.fill_en = 1'b1;
                if (sts.fill_last)
                    state_next = ST_DONE;
            end
            ST_FREE:
            begin
                cmd.free_en = 1'b1;
                if (sts.free_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* design/ffua_dpath.sv */
// Datapath of the first-fit unit allocator: owner table memory, scan
// counters, size register and result registers. Depends on ffua_pkg.
module ffua_dpath
#(
    parameter int MAX_UNITS = ffua_pkg::MAX_UNITS_DEF,
    parameter int ID_BITS   = ffua_pkg::ID_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ffua_pkg::SIZE_W-1:0]   cfg_size,
    input  logic                          in_func,
    input  logic [ffua_pkg::REQ_W-1:0]    in_req,
    input  logic [ffua_pkg::OID_W-1:0]    in_id,
    input  ffua_pkg::cmd_t                cmd,
    output ffua_pkg::sts_t                sts,
    output logic                          out_status,
    output logic [ffua_pkg::START_W-1:0]  out_start,
    output logic [ffua_pkg::FREED_W-1:0]  out_freed
);
    import ffua_pkg::*;

    localparam int AW = $clog2(MAX_UNITS);
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;

    logic [ID_BITS-1:0] mem [MAX_UNITS];
    logic [ID_BITS-1:0] rdata_reg;

    logic [SIZE_W-1:0]  size_reg;
    logic [CW-1:0]      addr_reg;
    logic               rv_reg;

    logic               func_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [AW-1:0]      raddr_reg;
    logic [LW-1:0]      run_reg;
    logic [AW-1:0]      fill_reg;
    logic [REQ_W-1:0]   left_reg;
    logic [START_W-1:0] start_reg;
    logic               fail_reg;
    logic [FREED_W-1:0] freed_reg;

    logic [LW-1:0]      limit;
    logic [LW-1:0]      run_inc;
    logic [LW-1:0]      start_full;
    logic               rd_alloc;
    logic               rd_free;
    logic               free_hit;
    logic               re;
    logic [AW-1:0]      ra;
    logic               we;
    logic [AW-1:0]      wa;
    logic [ID_BITS-1:0] wd;

    assign limit = (LW'(size_reg) > LW'(MAX_UNITS)) ? LW'(MAX_UNITS) : LW'(size_reg);
    assign run_inc    = run_reg + LW'(1);
    assign start_full = LW'(raddr_reg) + LW'(1) - LW'(req_reg);
    assign rd_alloc   = LW'(addr_reg) < limit;
    assign rd_free    = addr_reg < CW'(MAX_UNITS);
    assign free_hit   = rv_reg && (rdata_reg == id_reg);

    always_comb
    begin
        sts.func_free = (func_reg == FUNC_FREE);
        sts.id_ok     = (id_reg != '0);
        sts.alloc_ok  = (req_reg != '0) && (id_reg != '0) && (LW'(req_reg) <= limit);
        sts.found     = rv_reg && (rdata_reg == '0) && (run_inc == LW'(req_reg));
        sts.scan_end  = !rv_reg && !rd_alloc;
        sts.free_end  = !rv_reg && !rd_free;
        sts.fill_last = (left_reg == REQ_W'(1));
        sts.clr_last  = (addr_reg == CW'(MAX_UNITS - 1));
    end

    // table ports
    always_comb
    begin
        re = (cmd.alloc_en && rd_alloc) || (cmd.free_en && rd_free);
        ra = addr_reg[AW-1:0];
        we = 1'b0;
        wa = addr_reg[AW-1:0];
        wd = '0;
        if (cmd.clr_en)
            we = 1'b1;
        else if (cmd.fill_en)
        begin
            we = 1'b1;
            wa = fill_reg;
            wd = id_reg;
        end
        else if (cmd.free_en && free_hit)
        begin
            we = 1'b1;
            wa = raddr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rdata_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            addr_reg <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                size_reg <= cfg_size;
            if (cmd.load)
            begin
                addr_reg <= '0;
                rv_reg   <= 1'b0;
            end
            else if (cmd.clr_en)
                addr_reg <= addr_reg + CW'(1);
            else if (cmd.alloc_en || cmd.free_en)
            begin
                rv_reg <= re;
                if (re)
                    addr_reg <= addr_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_func;
            req_reg   <= in_req;
            id_reg    <= ID_BITS'(in_id);
            run_reg   <= '0;
            fail_reg  <= 1'b0;
            start_reg <= '0;
            freed_reg <= '0;
        end
        if (re)
            raddr_reg <= addr_reg[AW-1:0];
        if (cmd.alloc_en && rv_reg)
        begin
            run_reg <= (rdata_reg == '0) ? run_inc : '0;
            if (sts.found)
            begin
                start_reg <= START_W'(start_full);
                fill_reg  <= AW'(start_full);
                left_reg  <= req_reg;
            end
        end
        if (cmd.fill_en)
        begin
            fill_reg <= fill_reg + AW'(1);
            left_reg <= left_reg - REQ_W'(1);
        end
        if (cmd.free_en && free_hit && (freed_reg != FREED_MAX))
            freed_reg <= freed_reg + FREED_W'(1);
        if (cmd.set_fail)
        begin
            fail_reg  <= 1'b1;
            start_reg <= '0;
        end
        if (cmd.out_load)
        begin
            out_status <= fail_reg ? STS_NOSPACE : STS_OK;
            out_start  <= start_reg;
            out_freed  <= freed_reg;
        end
    end

endmodule
